FILE: rtl/core/nfsf_pkg.sv
// Package for the next free slot finder: store geometry, opcodes and
// helpers that move values between the 16-bit slot domain and store addresses.
// Used by the top level and the checker; depends on nothing.
`default_nettype none

package nfsf_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DATA_W      = 16;
    localparam int MAX_COUNT   = (STORE_DEPTH - 2 < 65534) ? STORE_DEPTH - 2 : 65534;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam logic OP_REMOVE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam t_word MAX_COUNT_W  = t_word'(MAX_COUNT);
    localparam t_word RESET_COUNT  = 16'd65534;
    localparam t_addr LAST_ADDR    = t_addr'(STORE_DEPTH - 1);

    function automatic t_addr to_addr(input t_word v);
        logic [31:0] w;
        w = 32'(v);
        return w[ADDR_W-1:0];
    endfunction

    function automatic t_word to_word(input t_addr a);
        logic [31:0] w;
        w = 32'(a);
        return w[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nfsf_link_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Holds the link store of the next free slot finder; no package dependency.
`default_nettype none

module nfsf_link_ram #(
    parameter int DEPTH  = 65536,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/next_free_slot_finder.sv
// Top level of the next free slot finder: control sequencer around the link store.
// Depends on nfsf_pkg and nfsf_link_ram.
//
// Usage. An item (i_opcode, i_slot_index) is taken at a rising edge where start
// is high and busy is low. A remove marks the slot as taken and gives no result.
// A query gives one result, o_found and o_free_index, shown for exactly one
// cycle with o_valid; the receiver cannot stall and must take it then.
// Writing i_cfg_wdata with i_cfg_we sets slot_count and refills the link store.
// Walks. Every read of the link store returns its registered data in the next cycle,
// and following one link takes the states ST_READ and ST_HALVE (read link, read
// grandparent and write back). A valid query walks its k links, a valid remove
// makes two walks; items with a slot index out of range need no walk.
// With path halving k stays small when amortized.
// Reset and configuration. After reset and after every slot_count write the
// block sweeps the store back to the identity, one entry per cycle, over all
// STORE_DEPTH (65536) entries; busy stays high during the sweep.
// Reset is synchronous and active low.
`default_nettype none

module next_free_slot_finder (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_opcode,
    input  wire nfsf_pkg::t_word       i_slot_index,
    input  wire logic                  i_cfg_we,
    input  wire nfsf_pkg::t_word       i_cfg_wdata,
    output logic                       o_valid,
    output logic                       o_found,
    output nfsf_pkg::t_word            o_free_index
);
    import nfsf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_HALVE = 2'd3;

    logic [1:0] r_state, n_state;
    t_addr      r_clr, n_clr;
    t_word      r_slot_count, n_slot_count;
    t_word      r_cur, n_cur;
    t_word      r_x, n_x;
    t_word      r_rx, n_rx;
    logic       r_op, n_op;
    logic       r_phase, n_phase;
    logic       r_out_valid, n_out_valid;
    logic       r_out_found, n_out_found;
    t_word      r_out_index, n_out_index;

    logic  ram_we;
    t_addr ram_waddr;
    t_word ram_wdata;
    t_addr ram_raddr;
    t_word ram_rdata;

    t_word eff_count;
    t_word sentinel;
    logic  in_range;

    nfsf_link_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (DATA_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign eff_count = (r_slot_count > MAX_COUNT_W) ? MAX_COUNT_W : r_slot_count;
    assign sentinel  = eff_count + 16'd1;
    assign in_range  = (i_slot_index != '0) && (i_slot_index <= eff_count);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_slot_count = r_slot_count;
        n_cur        = r_cur;
        n_x          = r_x;
        n_rx         = r_rx;
        n_op         = r_op;
        n_phase      = r_phase;
        n_out_valid  = 1'b0;
        n_out_found  = r_out_found;
        n_out_index  = r_out_index;
        ram_we       = 1'b0;
        ram_waddr    = to_addr(r_cur);
        ram_wdata    = r_cur;
        ram_raddr    = to_addr(r_cur);

        if (i_cfg_we) begin
            n_slot_count = i_cfg_wdata;
            n_clr        = '0;
            n_state      = ST_CLEAR;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        if (in_range) begin
                            n_cur     = i_slot_index;
                            n_x       = i_slot_index;
                            n_op      = i_opcode;
                            n_phase   = 1'b0;
                            ram_raddr = to_addr(i_slot_index);
                            n_state   = ST_READ;
                        end else if (i_opcode == OP_QUERY) begin
                            n_out_valid = 1'b1;
                            n_out_found = 1'b0;
                            n_out_index = '0;
                        end
                    end
                end
                ST_CLEAR: begin
                    ram_we    = 1'b1;
                    ram_waddr = r_clr;
                    ram_wdata = to_word(r_clr);
                    n_clr     = r_clr + t_addr'(1);
                    if (r_clr == LAST_ADDR) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_READ: begin
                    if (ram_rdata == r_cur) begin
                        if (!r_phase) begin
                            if (r_op == OP_QUERY) begin
                                n_out_valid = 1'b1;
                                n_out_found = (r_cur != sentinel);
                                n_out_index = (r_cur != sentinel) ? r_cur : '0;
                                n_state     = ST_IDLE;
                            end else begin
                                n_rx      = r_cur;
                                n_phase   = 1'b1;
                                n_cur     = r_x + 16'd1;
                                ram_raddr = to_addr(r_x + 16'd1);
                            end
                        end else begin
                            if (r_rx != r_cur) begin
                                ram_we    = 1'b1;
                                ram_waddr = to_addr(r_rx);
                                ram_wdata = r_cur;
                            end
                            n_state = ST_IDLE;
                        end
                    end else begin
                        ram_raddr = to_addr(ram_rdata);
                        n_state   = ST_HALVE;
                    end
                end
                ST_HALVE: begin
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(r_cur);
                    ram_wdata = ram_rdata;
                    ram_raddr = to_addr(ram_rdata);
                    n_cur     = ram_rdata;
                    n_state   = ST_READ;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_slot_count <= RESET_COUNT;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_slot_count <= n_slot_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_x         <= n_x;
        r_rx        <= n_rx;
        r_op        <= n_op;
        r_phase     <= n_phase;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_free_index = r_out_index;

endmodule

`default_nettype wire

FILE: rtl/core/nfsf_checker.sv
// Port-level checker for the next free slot finder, bound to the top level.
// Depends on nfsf_pkg and next_free_slot_finder.
`default_nettype none

module nfsf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           i_opcode,
    input wire nfsf_pkg::t_word i_slot_index,
    input wire logic           i_cfg_we,
    input wire logic           o_valid,
    input wire logic           o_found,
    input wire nfsf_pkg::t_word o_free_index
);
    import nfsf_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> busy && !o_valid)
        else $error("store sweep did not start after reset");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy && !o_valid)
        else $error("store sweep did not start after a slot_count write");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_free_index == '0)
        else $error("not-found result carries a nonzero index");

    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_free_index != '0)
        else $error("found result carries index zero");

    a_zero_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_cfg_we && (i_opcode == OP_QUERY) && (i_slot_index == '0)
        |=> o_valid && !o_found)
        else $error("query of slot zero did not answer not found at once");

endmodule

bind next_free_slot_finder nfsf_checker u_nfsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_opcode     (i_opcode),
    .i_slot_index (i_slot_index),
    .i_cfg_we     (i_cfg_we),
    .o_valid      (o_valid),
    .o_found      (o_found),
    .o_free_index (o_free_index)
);

`default_nettype wire
